### rtl/pca_pkg.sv
// Shared types, widths and constants for the pixel colour adjust pipeline.
// Used by every module in rtl/; no dependencies.
`default_nettype none

package pca_pkg;

    localparam int FRAC_BITS = 8;

    localparam int STAGES = 10;

    localparam int ST_OFFSET   = 0;
    localparam int ST_CONTRAST = 1;
    localparam int ST_ROUND_X  = 2;
    localparam int ST_LUMA_MUL = 3;
    localparam int ST_LUMA_SUM = 4;
    localparam int ST_LUMA_RND = 5;
    localparam int ST_DIFF     = 6;
    localparam int ST_SAT_MUL  = 7;
    localparam int ST_SUM      = 8;
    localparam int ST_OUT      = 9;

    localparam int CHANNELS = 3;

    localparam int OFF_W  = 17;
    localparam int GAIN_W = 10;
    localparam int T_W    = 18;
    localparam int P_W    = T_W + GAIN_W + 1;
    localparam int XSHIFT = 16 - FRAC_BITS;
    localparam int XF_W   = P_W - XSHIFT;
    localparam int LP_W   = XF_W + 17;
    localparam int LW_W   = LP_W + 2;
    localparam int LF_W   = XF_W + 1;
    localparam int D_W    = LF_W + 1;
    localparam int M_W    = D_W + GAIN_W + 1;
    localparam int O_W    = M_W + 1;
    localparam int YSHIFT = FRAC_BITS + 8;

    localparam int MID_LEVEL = 128 * 256;
    localparam int CENTER_X  = 128 * 65536;

    localparam logic [15:0] LUMA_W [CHANNELS] = '{16'd19595, 16'd38470, 16'd7471};

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_OFFSET     = 2'd0;
    localparam logic [1:0] REG_CONTRAST   = 2'd1;
    localparam logic [1:0] REG_SATURATION = 2'd2;

    localparam logic signed [OFF_W-1:0] OFFSET_LIMIT     = 17'sd65280;
    localparam logic signed [OFF_W-1:0] OFFSET_LIMIT_NEG = -17'sd65280;
    localparam logic [GAIN_W-1:0]       GAIN_LIMIT       = 10'd512;
    localparam logic [GAIN_W-1:0]       GAIN_UNITY       = 10'd256;

    typedef struct packed {
        logic signed [OFF_W-1:0] offset;
        logic [GAIN_W-1:0]       contrast;
        logic [GAIN_W-1:0]       saturation;
    } cfg_t;

    // divide by 2^s, rounding half away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned s);
        logic [63:0] mag;
        logic [63:0] sum;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        sum = (mag << 1) + (64'd1 << s);
        q   = sum >> (s + 1);
        round_shift = v[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

### rtl/pixel_colour_adjust_unit.sv
// Top level: brightness, contrast and saturation adjustment of ARGB pixels.
// Depends on pca_pkg, pca_regs, pca_pipe_ctrl, pca_contrast, pca_luma, pca_saturate.
//
//   channel   dir  handshake          payload
//   s_*       in   s_valid/s_ready    red, green, blue, alpha in
//   m_*       out  m_valid/m_ready    red, green, blue, alpha out
//   APB       in   psel/penable       offset, contrast gain, saturation gain
//
// One pixel per clock while the output is not held by a low m_ready; ten-register pipeline.
// Reset clears all valid bits and loads the registers with offset 0, gains 1.0.
// A stage holds only when it and every stage after it are full and m_ready is low,
// so empty slots are filled while a result waits; nothing is lost or repeated.
`default_nettype none

module pixel_colour_adjust_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_red_in,
    input  wire logic [7:0]                     s_green_in,
    input  wire logic [7:0]                     s_blue_in,
    input  wire logic [7:0]                     s_alpha_in,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_red_out,
    output logic [7:0]                          m_green_out,
    output logic [7:0]                          m_blue_out,
    output logic [7:0]                          m_alpha_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pca_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [pca_pkg::DATA_W-1:0]     pwdata,
    output logic      [pca_pkg::DATA_W-1:0]     prdata,
    output logic                                pready
);

    pca_pkg::cfg_t cfg;
    logic [pca_pkg::STAGES-1:0] load;
    logic [7:0] chan_in  [pca_pkg::CHANNELS];
    logic [7:0] chan_out [pca_pkg::CHANNELS];
    logic signed [pca_pkg::XF_W-1:0] xf_c [pca_pkg::CHANNELS];
    logic signed [pca_pkg::XF_W-1:0] xf_l [pca_pkg::CHANNELS];
    logic signed [pca_pkg::LF_W-1:0] lf;
    logic [7:0] alpha_reg [pca_pkg::STAGES];

    pca_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pca_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .load    (load)
    );

    assign chan_in[0] = s_red_in;
    assign chan_in[1] = s_green_in;
    assign chan_in[2] = s_blue_in;

    for (genvar c = 0; c < pca_pkg::CHANNELS; c++) begin : g_front
        pca_contrast u_contrast (
            .aclk    (aclk),
            .load    (load),
            .cfg     (cfg),
            .chan_in (chan_in[c]),
            .xf_out  (xf_c[c])
        );
    end

    pca_luma u_luma (
        .aclk   (aclk),
        .load   (load),
        .xf_in  (xf_c),
        .xf_out (xf_l),
        .lf_out (lf)
    );

    for (genvar c = 0; c < pca_pkg::CHANNELS; c++) begin : g_back
        pca_saturate u_saturate (
            .aclk     (aclk),
            .load     (load),
            .cfg      (cfg),
            .xf_in    (xf_l[c]),
            .lf_in    (lf),
            .chan_out (chan_out[c])
        );
    end

    // alpha rides along the pipeline
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            alpha_reg[0] <= s_alpha_in;
        end
    end

    for (genvar k = 1; k < pca_pkg::STAGES; k++) begin : g_alpha
        always_ff @(posedge aclk) begin
            if (load[k]) begin
                alpha_reg[k] <= alpha_reg[k-1];
            end
        end
    end

    assign m_red_out   = chan_out[0];
    assign m_green_out = chan_out[1];
    assign m_blue_out  = chan_out[2];
    assign m_alpha_out = alpha_reg[pca_pkg::STAGES-1];

endmodule

`default_nettype wire

### rtl/pca_regs.sv
// APB register file: brightness offset, contrast gain, saturation gain.
// Depends on pca_pkg.
`default_nettype none

module pca_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pca_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [pca_pkg::DATA_W-1:0]    pwdata,
    output logic      [pca_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output pca_pkg::cfg_t                      cfg
);

    pca_pkg::cfg_t cfg_reg;
    pca_pkg::cfg_t cfg_next;
    logic [1:0] idx;
    logic signed [pca_pkg::OFF_W-1:0] off_in;
    logic [pca_pkg::GAIN_W-1:0] gain_in;
    logic [pca_pkg::GAIN_W-1:0] gain_sat;

    assign idx      = paddr[3:2];
    assign off_in   = $signed(pwdata[pca_pkg::OFF_W-1:0]);
    assign gain_in  = pwdata[pca_pkg::GAIN_W-1:0];
    assign gain_sat = (gain_in > pca_pkg::GAIN_LIMIT) ? pca_pkg::GAIN_LIMIT : gain_in;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (idx)
                pca_pkg::REG_OFFSET: begin
                    if (off_in > pca_pkg::OFFSET_LIMIT) begin
                        cfg_next.offset = pca_pkg::OFFSET_LIMIT;
                    end else if (off_in < pca_pkg::OFFSET_LIMIT_NEG) begin
                        cfg_next.offset = pca_pkg::OFFSET_LIMIT_NEG;
                    end else begin
                        cfg_next.offset = off_in;
                    end
                end
                pca_pkg::REG_CONTRAST: begin
                    cfg_next.contrast = gain_sat;
                end
                pca_pkg::REG_SATURATION: begin
                    cfg_next.saturation = gain_sat;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            pca_pkg::REG_OFFSET:     prdata = pca_pkg::DATA_W'(cfg_reg.offset);
            pca_pkg::REG_CONTRAST:   prdata = pca_pkg::DATA_W'(cfg_reg.contrast);
            pca_pkg::REG_SATURATION: prdata = pca_pkg::DATA_W'(cfg_reg.saturation);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset     <= '0;
            cfg_reg.contrast   <= pca_pkg::GAIN_UNITY;
            cfg_reg.saturation <= pca_pkg::GAIN_UNITY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pca_pipe_ctrl.sv
// Valid bits and per-stage load enables for the pixel pipeline.
// Depends on pca_pkg.
`default_nettype none

module pca_pipe_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [pca_pkg::STAGES-1:0]      load
);

    logic [pca_pkg::STAGES-1:0] valid_reg;
    logic [pca_pkg::STAGES-1:0] valid_next;
    logic [pca_pkg::STAGES:0]   ready_chain;

    assign ready_chain[pca_pkg::STAGES] = m_ready;

    // a stage takes data when empty or when the stage after it moves
    for (genvar k = 0; k < pca_pkg::STAGES; k++) begin : g_ready
        assign ready_chain[k] = !valid_reg[k] || ready_chain[k+1];
    end

    assign load       = ready_chain[pca_pkg::STAGES-1:0];
    assign valid_next = ({valid_reg[pca_pkg::STAGES-2:0], s_valid} & load)
                      | (valid_reg & ~load);
    assign s_ready    = ready_chain[0];
    assign m_valid    = valid_reg[pca_pkg::STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pca_contrast.sv
// One colour channel: brightness offset, contrast multiply, round to fixed point.
// Pipeline stages ST_OFFSET..ST_ROUND_X. Depends on pca_pkg.
`default_nettype none

module pca_contrast (
    input  wire logic                               aclk,
    input  wire logic [pca_pkg::STAGES-1:0]         load,
    input  wire pca_pkg::cfg_t                      cfg,
    input  wire logic [7:0]                         chan_in,
    output logic signed [pca_pkg::XF_W-1:0]         xf_out
);

    logic signed [pca_pkg::T_W-1:0]  t_reg;
    logic signed [pca_pkg::T_W-1:0]  t_next;
    logic signed [pca_pkg::P_W-1:0]  p_reg;
    logic signed [pca_pkg::P_W-1:0]  p_next;
    logic signed [pca_pkg::P_W-1:0]  x_sum;
    logic signed [pca_pkg::XF_W-1:0] xf_reg;
    logic signed [pca_pkg::XF_W-1:0] xf_next;

    assign t_next = pca_pkg::T_W'($signed({2'b00, chan_in, 8'h00}))
                  + pca_pkg::T_W'(cfg.offset)
                  - pca_pkg::T_W'(pca_pkg::MID_LEVEL);

    assign p_next = pca_pkg::P_W'(t_reg)
                  * pca_pkg::P_W'($signed({1'b0, cfg.contrast}));

    assign x_sum   = p_reg + pca_pkg::P_W'(pca_pkg::CENTER_X);
    assign xf_next = pca_pkg::XF_W'(pca_pkg::round_shift(64'(x_sum), pca_pkg::XSHIFT));
    assign xf_out  = xf_reg;

    always_ff @(posedge aclk) begin
        if (load[pca_pkg::ST_OFFSET]) begin
            t_reg <= t_next;
        end
        if (load[pca_pkg::ST_CONTRAST]) begin
            p_reg <= p_next;
        end
        if (load[pca_pkg::ST_ROUND_X]) begin
            xf_reg <= xf_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pca_luma.sv
// Rec.601 luma of the three adjusted channels: weight, sum, round.
// Pipeline stages ST_LUMA_MUL..ST_LUMA_RND; channels delayed alongside. Depends on pca_pkg.
`default_nettype none

module pca_luma (
    input  wire logic                               aclk,
    input  wire logic [pca_pkg::STAGES-1:0]         load,
    input  wire logic signed [pca_pkg::XF_W-1:0]    xf_in  [pca_pkg::CHANNELS],
    output logic signed [pca_pkg::XF_W-1:0]         xf_out [pca_pkg::CHANNELS],
    output logic signed [pca_pkg::LF_W-1:0]         lf_out
);

    logic signed [pca_pkg::LP_W-1:0] lp_reg  [pca_pkg::CHANNELS];
    logic signed [pca_pkg::LP_W-1:0] lp_next [pca_pkg::CHANNELS];
    logic signed [pca_pkg::XF_W-1:0] xf3_reg [pca_pkg::CHANNELS];
    logic signed [pca_pkg::XF_W-1:0] xf4_reg [pca_pkg::CHANNELS];
    logic signed [pca_pkg::XF_W-1:0] xf5_reg [pca_pkg::CHANNELS];
    logic signed [pca_pkg::LW_W-1:0] lw_reg;
    logic signed [pca_pkg::LW_W-1:0] lw_next;
    logic signed [pca_pkg::LF_W-1:0] lf_reg;
    logic signed [pca_pkg::LF_W-1:0] lf_next;

    for (genvar c = 0; c < pca_pkg::CHANNELS; c++) begin : g_chan
        assign lp_next[c] = pca_pkg::LP_W'(xf_in[c])
                          * pca_pkg::LP_W'($signed({1'b0, pca_pkg::LUMA_W[c]}));
        assign xf_out[c]  = xf5_reg[c];

        always_ff @(posedge aclk) begin
            if (load[pca_pkg::ST_LUMA_MUL]) begin
                lp_reg[c]  <= lp_next[c];
                xf3_reg[c] <= xf_in[c];
            end
            if (load[pca_pkg::ST_LUMA_SUM]) begin
                xf4_reg[c] <= xf3_reg[c];
            end
            if (load[pca_pkg::ST_LUMA_RND]) begin
                xf5_reg[c] <= xf4_reg[c];
            end
        end
    end

    assign lw_next = pca_pkg::LW_W'(lp_reg[0]) + pca_pkg::LW_W'(lp_reg[1])
                   + pca_pkg::LW_W'(lp_reg[2]);
    assign lf_next = pca_pkg::LF_W'(pca_pkg::round_shift(64'(lw_reg), 16));
    assign lf_out  = lf_reg;

    always_ff @(posedge aclk) begin
        if (load[pca_pkg::ST_LUMA_SUM]) begin
            lw_reg <= lw_next;
        end
        if (load[pca_pkg::ST_LUMA_RND]) begin
            lf_reg <= lf_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pca_saturate.sv
// One colour channel: push away from luma by the saturation gain, round, clamp.
// Pipeline stages ST_DIFF..ST_OUT. Depends on pca_pkg.
`default_nettype none

module pca_saturate (
    input  wire logic                               aclk,
    input  wire logic [pca_pkg::STAGES-1:0]         load,
    input  wire pca_pkg::cfg_t                      cfg,
    input  wire logic signed [pca_pkg::XF_W-1:0]    xf_in,
    input  wire logic signed [pca_pkg::LF_W-1:0]    lf_in,
    output logic [7:0]                              chan_out
);

    logic signed [pca_pkg::D_W-1:0]  d_reg;
    logic signed [pca_pkg::D_W-1:0]  d_next;
    logic signed [pca_pkg::LF_W-1:0] lf6_reg;
    logic signed [pca_pkg::LF_W-1:0] lf7_reg;
    logic signed [pca_pkg::M_W-1:0]  m_reg;
    logic signed [pca_pkg::M_W-1:0]  m_next;
    logic signed [pca_pkg::O_W-1:0]  o_reg;
    logic signed [pca_pkg::O_W-1:0]  o_next;
    logic signed [63:0]              y;
    logic [7:0]                      out_reg;
    logic [7:0]                      out_next;

    assign d_next = pca_pkg::D_W'(xf_in) - pca_pkg::D_W'(lf_in);
    assign m_next = pca_pkg::M_W'(d_reg)
                  * pca_pkg::M_W'($signed({1'b0, cfg.saturation}));
    assign o_next = pca_pkg::O_W'(m_reg) + (pca_pkg::O_W'(lf7_reg) <<< 8);

    always_comb begin
        y = pca_pkg::round_shift(64'(o_reg), pca_pkg::YSHIFT);
        if (y < 64'sd0) begin
            out_next = 8'd0;
        end else if (y > 64'sd255) begin
            out_next = 8'd255;
        end else begin
            out_next = y[7:0];
        end
    end

    assign chan_out = out_reg;

    always_ff @(posedge aclk) begin
        if (load[pca_pkg::ST_DIFF]) begin
            d_reg   <= d_next;
            lf6_reg <= lf_in;
        end
        if (load[pca_pkg::ST_SAT_MUL]) begin
            m_reg   <= m_next;
            lf7_reg <= lf6_reg;
        end
        if (load[pca_pkg::ST_SUM]) begin
            o_reg <= o_next;
        end
        if (load[pca_pkg::ST_OUT]) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### sim/pca_adjust_checker.sv
// Checker for pixel_colour_adjust_unit: follows register writes, predicts each adjusted
// pixel and compares it with the output transaction. Depends on pca_pkg.
module pca_adjust_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [7:0]                  s_red_in,
    input  logic [7:0]                  s_green_in,
    input  logic [7:0]                  s_blue_in,
    input  logic [7:0]                  s_alpha_in,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [7:0]                  m_red_out,
    input  logic [7:0]                  m_green_out,
    input  logic [7:0]                  m_blue_out,
    input  logic [7:0]                  m_alpha_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [pca_pkg::ADDR_W-1:0]  paddr,
    input  logic [pca_pkg::DATA_W-1:0]  pwdata,
    output int                          error_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC       = pca_pkg::FRAC_BITS;
    localparam longint WEIGHT_R   = 19595;
    localparam longint WEIGHT_G   = 38470;
    localparam longint WEIGHT_B   = 7471;
    localparam longint MID_Q8     = 128 * 256;
    localparam longint CENTER_Q16 = 128 * 65536;
    localparam longint OFFSET_MAX = 65280;
    localparam longint GAIN_MAX   = 512;
    localparam longint GAIN_ONE   = 256;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    pixel_t adjusted_pixels[$];
    longint offset_q8;
    longint contrast_q8;
    longint saturation_q8;

    // divide by 2^s, ties away from zero
    function automatic longint round_away(longint v, int s);
        longint mag;
        if (s == 0)
            return v;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint contrast_level(logic [7:0] c);
        longint t;
        t = longint'(c) * 256 + offset_q8 - MID_Q8;
        return round_away(t * contrast_q8 + CENTER_Q16, 16 - FRAC);
    endfunction

    function automatic logic [7:0] saturate_level(longint xf, longint lf);
        longint y;
        y = round_away(lf * 256 + (xf - lf) * saturation_q8, FRAC + 8);
        if (y < 0)
            y = 0;
        if (y > 255)
            y = 255;
        return 8'(y);
    endfunction

    function automatic pixel_t adjust_pixel(pixel_t p);
        longint rf;
        longint gf;
        longint bf;
        longint lf;
        pixel_t q;
        rf = contrast_level(p.red);
        gf = contrast_level(p.green);
        bf = contrast_level(p.blue);
        lf = round_away(rf * WEIGHT_R + gf * WEIGHT_G + bf * WEIGHT_B, 16);
        q.red   = saturate_level(rf, lf);
        q.green = saturate_level(gf, lf);
        q.blue  = saturate_level(bf, lf);
        q.alpha = p.alpha;
        return q;
    endfunction

    task automatic compare_level(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : track
        pixel_t     want;
        longint     off;
        longint     gain;
        logic [1:0] reg_index;
        if (!aresetn) begin
            adjusted_pixels.delete();
            offset_q8     = 0;
            contrast_q8   = GAIN_ONE;
            saturation_q8 = GAIN_ONE;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_index = 2'(paddr >> 2);
                off  = longint'($signed(pwdata[pca_pkg::OFF_W-1:0]));
                gain = longint'(pwdata[pca_pkg::GAIN_W-1:0]);
                if (off > OFFSET_MAX)
                    off = OFFSET_MAX;
                if (off < -OFFSET_MAX)
                    off = -OFFSET_MAX;
                if (gain > GAIN_MAX)
                    gain = GAIN_MAX;
                case (reg_index)
                    pca_pkg::REG_OFFSET:     offset_q8 = off;
                    pca_pkg::REG_CONTRAST:   contrast_q8 = gain;
                    pca_pkg::REG_SATURATION: saturation_q8 = gain;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (adjusted_pixels.size() == 0) begin
                    $display("%0t: output transaction with nothing expected, got %0d %0d %0d %0d",
                             $time, m_red_out, m_green_out, m_blue_out, m_alpha_out);
                    error_count++;
                end else begin
                    want = adjusted_pixels.pop_front();
                    compare_level("red", want.red, m_red_out);
                    compare_level("green", want.green, m_green_out);
                    compare_level("blue", want.blue, m_blue_out);
                    compare_level("alpha", want.alpha, m_alpha_out);
                end
            end
            if (s_valid && s_ready)
                adjusted_pixels.insert(adjusted_pixels.size(),
                                       adjust_pixel({s_red_in, s_green_in, s_blue_in,
                                                     s_alpha_in}));
        end
        outstanding = adjusted_pixels.size();
    end

endmodule

### sim/pixel_colour_adjust_unit_test.sv
// Testbench top for pixel_colour_adjust_unit: clock, reset, pixel and register stimulus,
// output back-pressure and the verdict. Depends on pca_pkg, the RTL and pca_adjust_checker.
module pixel_colour_adjust_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PHASES           = 12;
    localparam int         PIXELS_PER_PHASE = 112;
    localparam int         HOLD_AFTER       = 400;
    localparam int         HOLD_CYCLES      = 250;
    localparam int         CYCLE_LIMIT      = 200000;
    localparam logic [1:0] REG_UNMAPPED     = 2'd3;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [7:0]                  s_red_in;
    logic [7:0]                  s_green_in;
    logic [7:0]                  s_blue_in;
    logic [7:0]                  s_alpha_in;
    logic                        m_valid;
    logic                        m_ready;
    logic [7:0]                  m_red_out;
    logic [7:0]                  m_green_out;
    logic [7:0]                  m_blue_out;
    logic [7:0]                  m_alpha_out;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [pca_pkg::ADDR_W-1:0]  paddr;
    logic [pca_pkg::DATA_W-1:0]  pwdata;
    logic [pca_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    int checker_errors;
    int outstanding;
    int sent_count;
    int cycle_count;
    bit calm;

    pixel_colour_adjust_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pca_adjust_checker adjust_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .error_count (checker_errors),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pixel_colour_adjust_unit_test: errors");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off to back the pipe up
    initial begin : sink
        int  idle_left;
        bit  held;
        idle_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && sent_count >= HOLD_AFTER) begin
                held      = 1'b1;
                idle_left = HOLD_CYCLES;
            end else if (idle_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 7);
            end
            if (idle_left > 0) begin
                m_ready <= 1'b0;
                idle_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        s_alpha_in <= a;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(120, 136));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'd0;
            2: return 32'd512;
            3: return 32'd256;
            default: return 32'($urandom_range(0, 512));
        endcase
    endfunction

    task automatic write_random_settings();
        int off;
        case ($urandom_range(0, 4))
            0: off = int'($urandom());
            1: off = $urandom_range(0, 1) ? 65280 : -65280;
            2: off = int'($urandom_range(0, 4096)) - 2048;
            default: off = int'($urandom_range(0, 130560)) - 65280;
        endcase
        write_reg(pca_pkg::REG_OFFSET, 32'(off));
        write_reg(pca_pkg::REG_CONTRAST, random_gain());
        write_reg(pca_pkg::REG_SATURATION, random_gain());
    endtask

    initial begin : stimulus
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_red_in   = '0;
        s_green_in = '0;
        s_blue_in  = '0;
        s_alpha_in = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        calm       = 1'b0;
        sent_count = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: unity gains, no offset
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'h55, 8'hAA, 8'h0F, 8'hF0);
        send_pixel(8'd128, 8'd127, 8'd1, 8'd254);
        settle();

        // offsets past +/-255 levels clip
        write_reg(pca_pkg::REG_OFFSET, 32'h0000_FFFF);
        send_pixel(8'd0, 8'd100, 8'd255, 8'h0F);
        settle();
        write_reg(pca_pkg::REG_OFFSET, 32'h0001_0000);
        send_pixel(8'd255, 8'd200, 8'd0, 8'hF0);
        settle();

        // gains past 2.0 clip
        write_reg(pca_pkg::REG_OFFSET, 32'd128);
        write_reg(pca_pkg::REG_CONTRAST, 32'h3FF);
        write_reg(pca_pkg::REG_SATURATION, 32'd0);
        send_pixel(8'd10, 8'd128, 8'd250, 8'd7);
        send_pixel(8'd0, 8'd255, 8'd127, 8'd200);
        settle();
        write_reg(pca_pkg::REG_OFFSET, 32'hFFFF_8000);
        write_reg(pca_pkg::REG_CONTRAST, 32'd0);
        write_reg(pca_pkg::REG_SATURATION, 32'h3FF);
        send_pixel(8'd0, 8'd0, 8'd255, 8'h80);
        send_pixel(8'd255, 8'd0, 8'd0, 8'h01);
        settle();

        // write to an unmapped address must leave settings alone
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_pixel(8'd60, 8'd180, 8'd90, 8'h3C);
        settle();

        write_reg(pca_pkg::REG_OFFSET, 32'd65280);
        write_reg(pca_pkg::REG_CONTRAST, 32'd512);
        write_reg(pca_pkg::REG_SATURATION, 32'd512);
        send_pixel(8'd128, 8'd128, 8'd128, 8'hC3);
        send_pixel(8'd1, 8'd2, 8'd3, 8'd4);
        send_pixel(8'd250, 8'd5, 8'd128, 8'h7E);
        settle();
        write_reg(pca_pkg::REG_OFFSET, 32'(-65280));
        write_reg(pca_pkg::REG_CONTRAST, 32'd256);
        send_pixel(8'd255, 8'd255, 8'd0, 8'h99);
        send_pixel(8'd0, 8'd0, 8'd0, 8'h66);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            write_random_settings();
            calm = (phase == PHASES - 1);
            repeat (PIXELS_PER_PHASE)
                send_pixel(random_level(), random_level(), random_level(), 8'($urandom()));
            settle();
        end

        repeat (2 * pca_pkg::STAGES) @(negedge aclk);
        if (checker_errors == 0)
            $display("pixel_colour_adjust_unit_test: clean");
        else
            $display("pixel_colour_adjust_unit_test: errors");
        $finish;
    end

endmodule
